FILE: rtl/core/pat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pat_pkg;

    // Window depth and field widths.
    localparam int WINDOW = 10;
    localparam int SMP_W  = 13;
    localparam int FRAC_W = 16;

    // Derived widths for the window bookkeeping and the divider.
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = $clog2(WINDOW * ((1 << SMP_W) - 1) + 1);
    localparam int DEN_W     = CNT_W + SMP_W;
    localparam int REM_W     = DEN_W + 1;
    localparam int DIV_CNT_W = $clog2(FRAC_W + 2);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_W + 1);
    localparam logic [CNT_W-1:0]     FILL_FULL = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0]    SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [FRAC_W-1:0]    FRAC_ONE  = 16'h8000;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_GAS_FULL_SCALE    = 2'd0;
    localparam logic [1:0] CFG_BRAKE_FULL_SCALE  = 2'd1;
    localparam logic [1:0] CFG_GAS_DEADBAND      = 2'd2;
    localparam logic [1:0] CFG_BRAKE_LIGHT_LEVEL = 2'd3;

    localparam logic [SMP_W-1:0]  RST_GAS_FULL_SCALE    = 13'd8191;
    localparam logic [SMP_W-1:0]  RST_BRAKE_FULL_SCALE  = 13'd8191;
    localparam logic [FRAC_W-1:0] RST_GAS_DEADBAND      = 16'd983;
    localparam logic [FRAC_W-1:0] RST_BRAKE_LIGHT_LEVEL = 16'd3277;

    // One poll of both pedals.
    typedef struct packed {
        logic [SMP_W-1:0] gas_sample;
        logic [SMP_W-1:0] brake_sample;
    } t_in_item;

    // One filtered result.
    typedef struct packed {
        logic [FRAC_W-1:0] gas_fraction;
        logic [FRAC_W-1:0] brake_fraction;
        logic              brake_lamp;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_B_LOAD,
        S_B_RUN,
        S_G_LOAD,
        S_G_RUN,
        S_OUTPUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic div_start;
        logic div_gas;
        logic div_step;
        logic div_store;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/core/pat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pat_ctrl
    import pat_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_B_LOAD;
            end
            S_B_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_B_RUN;
            end
            S_B_RUN: begin
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_G_LOAD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_G_LOAD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_gas   = 1'b1;
                n_state         = S_G_RUN;
            end
            S_G_RUN: begin
                o_cmd.div_gas = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_OUTPUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUTPUT: begin
                // Load the output register once the previous result is gone.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/pat_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pat_datapath
    import pat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_in_item    i_in_data,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    output t_out_item        o_out_data
);

    // Configuration registers.
    logic [SMP_W-1:0]  r_gas_fs;
    logic [SMP_W-1:0]  r_brake_fs;
    logic [FRAC_W-1:0] r_deadband;
    logic [FRAC_W-1:0] r_light;

    // Window state.
    t_in_item          r_mem [WINDOW];
    t_in_item          r_in;
    t_in_item          r_old;
    logic [SUM_W-1:0]  r_gas_sum;
    logic [SUM_W-1:0]  r_brake_sum;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_fill;

    // Divider state.
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [SUM_W-2:0]     r_num_hi;
    logic [FRAC_W-1:0]    r_num_lo;
    logic [DEN_W-1:0]     r_den;
    logic [REM_W-1:0]     r_rem;
    logic [FRAC_W-1:0]    r_quo;
    logic                 r_ovf;

    // Per-pedal results.
    logic [FRAC_W-1:0] r_bf;
    logic [FRAC_W-1:0] r_gf;
    t_out_item         r_out;

    logic [SUM_W-1:0]  sel_sum;
    logic [SMP_W-1:0]  sel_fs;
    logic [SMP_W-1:0]  eff_fs;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  den_ext;
    logic              rem_ge;
    logic [FRAC_W-1:0] sat_frac;

    // Configuration writes; a zero full scale is treated as one later.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_fs   <= RST_GAS_FULL_SCALE;
            r_brake_fs <= RST_BRAKE_FULL_SCALE;
            r_deadband <= RST_GAS_DEADBAND;
            r_light    <= RST_BRAKE_LIGHT_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAS_FULL_SCALE:    r_gas_fs   <= i_cfg_data[SMP_W-1:0];
                CFG_BRAKE_FULL_SCALE:  r_brake_fs <= i_cfg_data[SMP_W-1:0];
                CFG_GAS_DEADBAND:      r_deadband <= i_cfg_data;
                CFG_BRAKE_LIGHT_LEVEL: r_light    <= i_cfg_data;
                default:               r_light    <= r_light;
            endcase
        end
    end

    // Sample window memory with a registered read of the current slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[r_slot] <= r_in;
        end
        r_old <= r_mem[r_slot];
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
    end

    // Running sums, write slot and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_sum   <= '0;
            r_brake_sum <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
        end else if (i_cmd.update) begin
            if (r_fill == FILL_FULL) begin
                r_gas_sum   <= r_gas_sum - SUM_W'(r_old.gas_sample)
                             + SUM_W'(r_in.gas_sample);
                r_brake_sum <= r_brake_sum - SUM_W'(r_old.brake_sample)
                             + SUM_W'(r_in.brake_sample);
            end else begin
                r_gas_sum   <= r_gas_sum + SUM_W'(r_in.gas_sample);
                r_brake_sum <= r_brake_sum + SUM_W'(r_in.brake_sample);
                r_fill      <= r_fill + CNT_W'(1);
            end
            r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
        end
    end

    // Operand selection for the shared divider.
    always_comb begin
        sel_sum   = i_cmd.div_gas ? r_gas_sum : r_brake_sum;
        sel_fs    = i_cmd.div_gas ? r_gas_fs : r_brake_fs;
        eff_fs    = (sel_fs == '0) ? SMP_W'(1) : sel_fs;
        den_ext   = REM_W'(r_den);
        rem_shift = {r_rem[REM_W-2:0], r_num_lo[FRAC_W-1]};
        rem_ge    = rem_shift >= den_ext;
        sat_frac  = (r_ovf || (r_quo > FRAC_ONE)) ? FRAC_ONE : r_quo;
    end

    // Restoring divider for sum * 2^15 / (count * full scale). The first
    // step checks whether the quotient overflows sixteen bits, then one
    // quotient bit is produced per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num_hi <= sel_sum[SUM_W-1:1];
            r_num_lo <= {sel_sum[0], {(FRAC_W-1){1'b0}}};
            r_den    <= DEN_W'(r_fill * eff_fs);
        end else if (i_cmd.div_step) begin
            if (r_div_cnt == '0) begin
                r_rem <= REM_W'(r_num_hi);
                r_ovf <= REM_W'(r_num_hi) >= den_ext;
            end else begin
                r_rem    <= rem_ge ? rem_shift - den_ext : rem_shift;
                r_quo    <= {r_quo[FRAC_W-2:0], rem_ge};
                r_num_lo <= {r_num_lo[FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Thresholds: brake first, then gas, which also yields to the brake.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            if (i_cmd.div_gas) begin
                r_gf <= ((sat_frac < r_deadband) || (r_bf != '0)) ? '0 : sat_frac;
            end else begin
                r_bf <= (sat_frac < r_light) ? '0 : sat_frac;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.gas_fraction   <= r_gf;
            r_out.brake_fraction <= r_bf;
            r_out.brake_lamp     <= r_bf > r_light;
        end
    end

    assign o_status.div_done = (r_div_cnt == DIV_LAST);
    assign o_out_data        = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/pedal_average_threshold_top.sv
// The shared restoring divider runs first for the brake and then for the gas
// fraction; a new input transaction is not accepted until the result of the
// previous one has been loaded into the output register.
// Input is accepted while an earlier result still waits in the output register.
// Reset is synchronous, active low: it empties the windows, clears the sums and
// restores the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pedal_average_threshold_top
    import pat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer for one poll at a time.
    pat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Windows, sums, divider and thresholds.
    pat_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/pat_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pat_checker
    import pat_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Only one poll is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a poll is still in work");

    // The lamp is on only with a nonzero brake fraction.
    a_lamp_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.brake_lamp |-> o_out_data.brake_fraction != '0)
        else $error("brake lamp on with zero brake fraction");

    // Gas reads zero whenever the brake is applied.
    a_gas_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.gas_fraction != '0)
        |-> o_out_data.brake_fraction == '0)
        else $error("gas and brake fractions both nonzero");

    // Fractions never exceed full scale.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.gas_fraction <= FRAC_ONE)
                     && (o_out_data.brake_fraction <= FRAC_ONE))
        else $error("fraction above full scale");

endmodule

bind pedal_average_threshold_top pat_checker u_pat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
